FILE: src/jsu_pkg.sv
package jsu_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
	localparam logic [2:0] ERR_CTRL       = 3'd2;
	localparam logic [2:0] ERR_UNF_ESC    = 3'd3;
	localparam logic [2:0] ERR_UNK_ESC    = 3'd4;
	localparam logic [2:0] ERR_UNF_UNI    = 3'd5;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd6;
	localparam logic [2:0] ERR_UNTERM     = 3'd7;

	// one queue entry: all results caused by one input byte
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] err;
		logic [1:0] cnt;    // number of results, 1 to 3
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} res_entry_t;

endpackage

FILE: src/json_string_unescape_top.sv
// JSON string unescaper. Feed a string literal one byte per request, starting with its opening
// quote (leading blanks are skipped); end_of_input flags the end of the text. Out come the
// decoded bytes, a done result on the closing quote, or one error result, after which the
// block looks for a new opening quote. A \u escape yields one to three UTF-8 bytes; surrogates
// are not paired. Input is taken at one byte per cycle unless full: the decoder handles each
// byte in the cycle it arrives and parks its results in a four-entry queue; the output drains
// one result per cycle while the reader pops, through the held-entry and output registers.
// A \u escape spends six bytes on at most three results, so the output keeps pace and full
// rises only when the reader stalls. last marks the final result caused by one input byte.
module json_string_unescape_top
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last
);

	logic       accept;
	logic       wr_en;
	res_entry_t wr_entry;
	logic       rd_en;
	res_entry_t rd_entry;
	logic       q_empty;

	assign accept = push && !full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.wr_en        (wr_en),
		.wr_entry     (wr_entry)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_entry (rd_entry),
		.full     (full),
		.empty    (q_empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_entry    (rd_entry),
		.q_rd       (rd_en),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

endmodule

FILE: src/jsu_front.sv
module jsu_front
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_input,
	output logic       wr_en,
	output res_entry_t wr_entry
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_STR  = 2'd1;
	localparam logic [1:0] PH_ESC  = 2'd2;
	localparam logic [1:0] PH_HEX  = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] code_point_q, code_point_d;
	logic        bad_hex_q, bad_hex_d;

	logic [3:0]  hex_dig;
	logic        hex_ok;
	logic [15:0] cp_next;
	logic        emit;
	res_entry_t  ent;

	always_comb begin
		hex_ok  = 1'b1;
		hex_dig = 4'd0;
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			hex_dig = data_byte[3:0];
		end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
		             (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
			hex_dig = data_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_next = {code_point_q[11:0], hex_dig};

	always_comb begin
		phase_d      = phase_q;
		hex_count_d  = hex_count_q;
		code_point_d = code_point_q;
		bad_hex_d    = bad_hex_q;
		emit         = 1'b0;
		ent          = '0;
		ent.kind     = KIND_BYTE;
		ent.err      = ERR_NONE;
		ent.cnt      = 2'd1;
		unique case (phase_q)
			PH_IDLE: begin
				if (!end_of_input && (data_byte == 8'h20 || data_byte == 8'h09 ||
				                      data_byte == 8'h0A || data_byte == 8'h0D)) begin
					emit = 1'b0;
				end else if (!end_of_input && data_byte == 8'h22) begin
					phase_d = PH_STR;
				end else begin
					emit     = 1'b1;
					ent.kind = KIND_ERR;
					ent.err  = ERR_NO_QUOTE;
				end
			end
			PH_STR: begin
				priority if (end_of_input) begin
					emit     = 1'b1;
					ent.kind = KIND_ERR;
					ent.err  = ERR_UNTERM;
					phase_d  = PH_IDLE;
				end else if (data_byte == 8'h22) begin
					emit     = 1'b1;
					ent.kind = KIND_DONE;
					phase_d  = PH_IDLE;
				end else if (data_byte < 8'h20) begin
					emit     = 1'b1;
					ent.kind = KIND_ERR;
					ent.err  = ERR_CTRL;
					phase_d  = PH_IDLE;
				end else if (data_byte == 8'h5C) begin
					phase_d = PH_ESC;
				end else begin
					emit      = 1'b1;
					ent.byte0 = data_byte;
				end
			end
			PH_ESC: begin
				if (end_of_input) begin
					emit     = 1'b1;
					ent.kind = KIND_ERR;
					ent.err  = ERR_UNF_ESC;
					phase_d  = PH_IDLE;
				end else begin
					phase_d = PH_STR;
					emit    = 1'b1;
					unique case (data_byte)
						8'h22, 8'h5C, 8'h2F: ent.byte0 = data_byte;
						8'h62: ent.byte0 = 8'h08;
						8'h66: ent.byte0 = 8'h0C;
						8'h6E: ent.byte0 = 8'h0A;
						8'h72: ent.byte0 = 8'h0D;
						8'h74: ent.byte0 = 8'h09;
						8'h75: begin
							emit         = 1'b0;
							phase_d      = PH_HEX;
							hex_count_d  = 2'd0;
							code_point_d = 16'd0;
							bad_hex_d    = 1'b0;
						end
						default: begin
							ent.kind = KIND_ERR;
							ent.err  = ERR_UNK_ESC;
							phase_d  = PH_IDLE;
						end
					endcase
				end
			end
			PH_HEX: begin
				if (end_of_input) begin
					emit     = 1'b1;
					ent.kind = KIND_ERR;
					ent.err  = ERR_UNF_UNI;
					phase_d  = PH_IDLE;
				end else begin
					code_point_d = cp_next;
					bad_hex_d    = bad_hex_q | ~hex_ok;
					if (hex_count_q != 2'd3) begin
						hex_count_d = hex_count_q + 2'd1;
					end else begin
						hex_count_d = 2'd0;
						emit        = 1'b1;
						if (bad_hex_q || !hex_ok) begin
							ent.kind = KIND_ERR;
							ent.err  = ERR_BAD_HEX;
							phase_d  = PH_IDLE;
						end else begin
							phase_d = PH_STR;
							priority if (cp_next[15:7] == 9'd0) begin
								ent.byte0 = cp_next[7:0];
							end else if (cp_next[15:11] == 5'd0) begin
								ent.cnt   = 2'd2;
								ent.byte0 = {3'b110, cp_next[10:6]};
								ent.byte1 = {2'b10, cp_next[5:0]};
							end else begin
								ent.cnt   = 2'd3;
								ent.byte0 = {4'hE, cp_next[15:12]};
								ent.byte1 = {2'b10, cp_next[11:6]};
								ent.byte2 = {2'b10, cp_next[5:0]};
							end
						end
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hex_count_q  <= 2'd0;
			code_point_q <= 16'd0;
			bad_hex_q    <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			hex_count_q  <= hex_count_d;
			code_point_q <= code_point_d;
			bad_hex_q    <= bad_hex_d;
		end
	end

	assign wr_en    = accept & emit;
	assign wr_entry = ent;

endmodule

FILE: src/jsu_queue.sv
module jsu_queue
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  res_entry_t wr_entry,
	input  logic       rd_en,
	output res_entry_t rd_entry,
	output logic       full,
	output logic       empty
);

	res_entry_t             mem_q [QueueDepth];
	logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QueueCntW-1:0]   count_q;

	assign full     = (count_q == QueueCntW'(QueueDepth));
	assign empty    = (count_q == '0);
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + QueueCntW'(1);
				2'b01:   count_q <= count_q - QueueCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/jsu_back.sv
module jsu_back
	import jsu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  res_entry_t q_entry,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [2:0] error_code,
	output logic       last
);

	res_entry_t cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [2:0] err_q;
	logic       last_q;

	logic       out_free;
	logic       adv;
	logic       cur_last;
	logic [7:0] cur_byte;

	assign out_free = !out_valid_q || pop;
	assign adv      = cur_valid_q && out_free;
	assign cur_last = (idx_q + 2'd1 == cur_q.cnt);
	// take the next request once the held one has gone out entirely
	assign q_rd     = !q_empty && (!cur_valid_q || (adv && cur_last));

	always_comb begin
		unique case (idx_q)
			2'd0:    cur_byte = cur_q.byte0;
			2'd1:    cur_byte = cur_q.byte1;
			default: cur_byte = cur_q.byte2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (adv) begin
				if (cur_last) begin
					cur_valid_q <= 1'b0;
				end
				idx_q <= idx_q + 2'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_entry;
		end
		if (adv) begin
			kind_q <= cur_q.kind;
			byte_q <= cur_byte;
			err_q  <= cur_q.err;
			last_q <= cur_last;
		end
	end

	assign empty      = !out_valid_q;
	assign kind       = kind_q;
	assign out_byte   = byte_q;
	assign error_code = err_q;
	assign last       = last_q;

endmodule

FILE: src/jsu_checker.sv
module jsu_checker
	import jsu_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic [2:0] error_code,
	input logic       last
);

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == KIND_BYTE || kind == KIND_DONE || kind == KIND_ERR))
		else $error("illegal result kind");

	a_code_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((kind == KIND_ERR) == (error_code != ERR_NONE)))
		else $error("error code does not match kind");

	a_no_byte_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != KIND_BYTE |-> out_byte == 8'd0 && last)
		else $error("done or error result carries a byte or is not last");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(kind) && $stable(out_byte) &&
			$stable(error_code) && $stable(last))
		else $error("stalled result changed");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.kind       (kind),
	.out_byte   (out_byte),
	.error_code (error_code),
	.last       (last)
);
